FILE: hw/rtl/grg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grg_pkg
// shared types of the givens rotation generator
// ----------------------------------------------------------------------------
package grg_pkg;

  // control flags that travel with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic neg_a;
    logic neg_b;
    logic zero;
  } ctl_t;

endpackage

FILE: hw/rtl/grg_isqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grg_isqrt_pipe
// pipelined integer square root, one root bit per register stage,
// returns floor(sqrt(x)) and the remainder x - root^2 from the last stage
// ----------------------------------------------------------------------------
module grg_isqrt_pipe #(
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [DW-1:0] rad_i,
  output logic [QW-1:0] root_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = ((2 * QW + 1) > (DW + 1)) ? (2 * QW + 1) : (DW + 1);

  logic [QW-1:0] root_q [QW];
  logic [DW-1:0] rem_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [QW-1:0] root_in;
    logic [DW-1:0] rem_in;
    logic [CW-1:0] cand;
    logic [CW-1:0] rem_ext;
    logic          take;

    // stage input
    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = rad_i;
    end else begin : g_next
      assign root_in = root_q[j-1];
      assign rem_in  = rem_q[j-1];
    end

    // (root + 2^B)^2 - root^2 against the remainder
    assign rem_ext = CW'(rem_in);
    assign cand    = (CW'(root_in) << (B + 1)) | (CW'(1) << (2 * B));
    assign take    = (cand <= rem_ext);

    always_ff @(posedge clk_i) begin
      root_q[j] <= take ? (root_in | (QW'(1) << B)) : root_in;
      rem_q[j]  <= take ? DW'(rem_ext - cand) : rem_in;
    end
  end

  // reset has nothing to clear in this datapath
  logic unused_rst;
  assign unused_rst = rst_ni;

  assign root_o = root_q[QW-1];
  assign rem_o  = rem_q[QW-1];

endmodule

FILE: hw/rtl/givens_rotation_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givens_rotation_generator_core
// plane rotation generator: (a, b) -> cosine, sine, radius, rounded to nearest
// ----------------------------------------------------------------------------
// Usage: drive first_value_i / second_value_i (signed, Q16.16 by default) and
// pulse start; the word is taken at every edge with start high and busy
// low. busy stays low, so a new word can enter on every clock cycle.
// Each word gives one result word on cosine_o / sine_o (signed Q2.F) and
// radius_o (unsigned, input binary point), shown for one cycle with done_o.
// Results leave in accept order. The angle path is a restoring divider
// of 2F+3 stages that forms a^2*2^(2F+2)/(a^2+b^2), then a square root
// of F+2 stages, one bit each. The radius root (IN_WIDTH stages) runs
// beside it; the shorter of the two paths is delayed to match.
// Throughput: one word per cycle.
// Reset clears the valid chain only; words in flight are dropped.
// The receiver cannot stall: each result is present for exactly one cycle.
// ----------------------------------------------------------------------------
module givens_rotation_generator_core #(
  parameter int IN_WIDTH        = 32,
  parameter int ANGLE_FRAC_BITS = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [IN_WIDTH-1:0]          first_value_i,
  input  logic [IN_WIDTH-1:0]          second_value_i,
  output logic                         done_o,
  output logic [ANGLE_FRAC_BITS+1:0]   cosine_o,
  output logic [ANGLE_FRAC_BITS+1:0]   sine_o,
  output logic [IN_WIDTH-1:0]          radius_o
);

  localparam int W       = IN_WIDTH;
  localparam int F       = ANGLE_FRAC_BITS;
  localparam int SW      = 2 * W;
  localparam int QB      = 2 * F + 3;
  localparam int RW      = F + 2;
  localparam int ANG_LAT = QB + RW;
  localparam int LAT     = (ANG_LAT > W) ? ANG_LAT : W;
  localparam int ANG_PAD = LAT - ANG_LAT;
  localparam int RAD_PAD = LAT - W;
  localparam int LATENCY = LAT + 4;

  assign busy = 1'b0;

  // control chain, one entry per stage
  grg_pkg::ctl_t ctl_d;
  grg_pkg::ctl_t ctl_q [LAT+3];

  assign ctl_d.valid = start & ~busy;
  assign ctl_d.neg_a = first_value_i[W-1];
  assign ctl_d.neg_b = second_value_i[W-1];
  assign ctl_d.zero  = (first_value_i == '0) && (second_value_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT + 3; k++) ctl_q[k] <= '0;
    end else begin
      ctl_q[0] <= ctl_d;
      for (int k = 1; k < LAT + 3; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // stage 0: magnitudes
  logic [W-1:0] mag_a_q, mag_b_q;
  always_ff @(posedge clk_i) begin
    mag_a_q <= first_value_i[W-1] ? W'(-first_value_i) : first_value_i;
    mag_b_q <= second_value_i[W-1] ? W'(-second_value_i) : second_value_i;
  end

  // stage 1: squares
  logic [SW-1:0] sq_a_q, sq_b_q;
  always_ff @(posedge clk_i) begin
    sq_a_q <= SW'(mag_a_q) * SW'(mag_a_q);
    sq_b_q <= SW'(mag_b_q) * SW'(mag_b_q);
  end

  // stage 2: sum of squares
  logic [SW-1:0] sum_q, xsq_q [2];
  always_ff @(posedge clk_i) begin
    sum_q    <= SW'(sq_a_q + sq_b_q);
    xsq_q[0] <= sq_a_q;
    xsq_q[1] <= sq_b_q;
  end

  // radius: root of the sum, then delay to match the longer path
  logic [W-1:0]  rad_root;
  logic [SW-1:0] rad_rem;
  logic [W-1:0]  rad_root_dl [RAD_PAD+1];
  logic [SW-1:0] rad_rem_dl  [RAD_PAD+1];

  grg_isqrt_pipe #(.DW(SW), .QW(W)) u_rad_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rad_i  (sum_q),
    .root_o (rad_root),
    .rem_o  (rad_rem)
  );

  assign rad_root_dl[0] = rad_root;
  assign rad_rem_dl[0]  = rad_rem;
  for (genvar k = 0; k < RAD_PAD; k++) begin : g_rad_pad
    always_ff @(posedge clk_i) begin
      rad_root_dl[k+1] <= rad_root_dl[k];
      rad_rem_dl[k+1]  <= rad_rem_dl[k];
    end
  end

  // angle paths: p = 0 cosine, p = 1 sine
  logic [RW-1:0] ang_root_dl [2][ANG_PAD+1];

  for (genvar p = 0; p < 2; p++) begin : g_ang
    logic [SW-1:0] drem_q [QB];
    logic [SW-1:0] dsum_q [QB];
    logic [QB-1:0] dquo_q [QB];
    logic [RW-1:0] ang_root;

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < QB; i++) begin : g_div
      logic [SW:0]   rin;
      logic [SW:0]   div_sum;
      logic [QB-1:0] quo_in;
      logic          ge;

      if (i == 0) begin : g_first
        assign rin     = {1'b0, xsq_q[p]};
        assign div_sum = {1'b0, sum_q};
        assign quo_in  = '0;
      end else begin : g_next
        assign rin     = {drem_q[i-1], 1'b0};
        assign div_sum = {1'b0, dsum_q[i-1]};
        assign quo_in  = dquo_q[i-1];
      end

      assign ge = (rin >= div_sum);

      always_ff @(posedge clk_i) begin
        drem_q[i] <= ge ? SW'(rin - div_sum) : SW'(rin);
        dsum_q[i] <= div_sum[SW-1:0];
        dquo_q[i] <= {quo_in[QB-2:0], ge};
      end
    end

    // twice the angle value, floored
    grg_isqrt_pipe #(.DW(QB), .QW(RW)) u_ang_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rad_i  (dquo_q[QB-1]),
      .root_o (ang_root),
      .rem_o  ()
    );

    assign ang_root_dl[p][0] = ang_root;
    for (genvar k = 0; k < ANG_PAD; k++) begin : g_ang_pad
      always_ff @(posedge clk_i) begin
        ang_root_dl[p][k+1] <= ang_root_dl[p][k];
      end
    end
  end

  // final stage: rounding and signs
  grg_pkg::ctl_t ctl_end;
  logic [RW:0]   cos_inc, sin_inc;
  logic [RW-1:0] cos_mag, sin_mag;
  logic          rad_up;
  logic [W-1:0]  radius_d;
  logic [RW-1:0] cosine_d, sine_d;

  assign ctl_end = ctl_q[LAT+2];
  assign cos_inc = {1'b0, ang_root_dl[0][ANG_PAD]} + (RW+1)'(1);
  assign sin_inc = {1'b0, ang_root_dl[1][ANG_PAD]} + (RW+1)'(1);
  assign cos_mag = cos_inc[RW:1];
  assign sin_mag = sin_inc[RW:1];
  assign rad_up  = (rad_rem_dl[RAD_PAD] > SW'(rad_root_dl[RAD_PAD]));

  always_comb begin
    radius_d = rad_root_dl[RAD_PAD] + W'(rad_up);
    cosine_d = ctl_end.neg_a ? RW'(-cos_mag) : cos_mag;
    sine_d   = ctl_end.neg_b ? RW'(-sin_mag) : sin_mag;
    if (ctl_end.zero) begin
      radius_d = '0;
      cosine_d = '0;
      sine_d   = '0;
    end
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_end.valid;
    end
  end

  logic [RW-1:0] cosine_q, sine_q;
  logic [W-1:0]  radius_q;
  always_ff @(posedge clk_i) begin
    cosine_q <= cosine_d;
    sine_q   <= sine_d;
    radius_q <= radius_d;
  end

  assign done_o   = done_q;
  assign cosine_o = cosine_q;
  assign sine_o   = sine_q;
  assign radius_o = radius_q;

  // every result word comes from a word taken a fixed time earlier
  a_done_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result word without a matching accepted word");

  // a zero radius comes only from the both-zero pair
  a_zero_radius : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && radius_o == '0) |-> (cosine_o == '0 && sine_o == '0))
    else $error("zero radius with a nonzero angle");

  // the cosine of a pair never exceeds one in magnitude
  a_cos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cosine_o[RW-1] == cosine_o[RW-2] || cosine_o[RW-3:0] == '0))
    else $error("cosine out of range");

endmodule

FILE: test/givens_rotation_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givens_rotation_generator_core_tb
// self-checking bench: each accepted (a, b) word is predicted with exact wide
// integer math and every done_o word is compared in order with the prediction
// ----------------------------------------------------------------------------
module givens_rotation_generator_core_tb;

  localparam int W  = 32;
  localparam int F  = 30;
  localparam int LATENCY = 3 + ((W > 3 * F + 5) ? W : 3 * F + 5) + 1;

  typedef logic [129:0] wide_t;

  typedef struct {
    logic [F+1:0] cosine;
    logic [F+1:0] sine;
    logic [W-1:0] radius;
  } rotation_t;

  // rotation predictor and in-order store of expected words
  class rotation_scoreboard;
    rotation_t expected_q[$];
    int        errors;

    function automatic wide_t angle_mag(wide_t x, wide_t sum);
      wide_t lim, d, k, t;
      lim = (x * x) << (2 * F + 2);
      k = '0;
      for (int bit_i = F; bit_i >= 0; bit_i--) begin
        t = k | (wide_t'(1) << bit_i);
        d = 2 * t - 1;
        if (d * d * sum <= lim) k = t;
      end
      return k;
    endfunction

    function void note(logic [W-1:0] a, logic [W-1:0] b);
      rotation_t exp_w;
      wide_t     ma, mb, sum, q, t, kc, ks;
      ma = a[W-1] ? wide_t'(-a) : wide_t'(a);
      mb = b[W-1] ? wide_t'(-b) : wide_t'(b);
      ma = ma & ((wide_t'(1) << W) - 1);
      mb = mb & ((wide_t'(1) << W) - 1);
      sum = ma * ma + mb * mb;
      if (sum == 0) begin
        exp_w = '{cosine: '0, sine: '0, radius: '0};
      end else begin
        // integer root, then round to nearest
        q = '0;
        for (int bit_i = W; bit_i >= 0; bit_i--) begin
          t = q | (wide_t'(1) << bit_i);
          if (t * t <= sum) q = t;
        end
        if (sum > q * q + q) q = q + 1;
        kc = angle_mag(ma, sum);
        ks = angle_mag(mb, sum);
        exp_w.cosine = a[W-1] ? -kc[F+1:0] : kc[F+1:0];
        exp_w.sine   = b[W-1] ? -ks[F+1:0] : ks[F+1:0];
        exp_w.radius = q[W-1:0];
      end
      expected_q.push_back(exp_w);
    endfunction

    function void check(logic [F+1:0] c, logic [F+1:0] s, logic [W-1:0] r);
      rotation_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word c=%h s=%h r=%h", $time, c, s, r);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (c !== exp_w.cosine) begin
        $display("%0t: cosine expected %h actual %h", $time, exp_w.cosine, c);
        errors++;
      end
      if (s !== exp_w.sine) begin
        $display("%0t: sine expected %h actual %h", $time, exp_w.sine, s);
        errors++;
      end
      if (r !== exp_w.radius) begin
        $display("%0t: radius expected %h actual %h", $time, exp_w.radius, r);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  logic [W-1:0]   first_value_i;
  logic [W-1:0]   second_value_i;
  logic           done_o;
  logic [F+1:0]   cosine_o;
  logic [F+1:0]   sine_o;
  logic [W-1:0]   radius_o;

  rotation_scoreboard rot_sb;
  int                 idle_pct;

  givens_rotation_generator_core #(
    .IN_WIDTH       (W),
    .ANGLE_FRAC_BITS(F)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .first_value_i (first_value_i),
    .second_value_i(second_value_i),
    .done_o        (done_o),
    .cosine_o      (cosine_o),
    .sine_o        (sine_o),
    .radius_o      (radius_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) rot_sb.check(cosine_o, sine_o, radius_o);
  end

  // send one word, called at a falling edge, returns at a falling edge
  task automatic send_pair(logic [W-1:0] a, logic [W-1:0] b);
    // each cycle is idle with probability idle_pct percent
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start          = 1'b1;
    first_value_i  = a;
    second_value_i = b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    rot_sb.note(a, b);
    @(negedge clk_i);
  endtask

  function automatic logic [W-1:0] rand_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return W'($signed($urandom_range(2000)) - 1000);
      2:       return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // random pairs: general, one side zero, equal or opposite magnitudes
  task automatic send_random(int count);
    logic [W-1:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = rand_value();
      b = rand_value();
      case ($urandom_range(9))
        0: a = '0;
        1: b = '0;
        2: b = $urandom_range(1) ? a : -a;
        default: ;
      endcase
      send_pair(a, b);
    end
  endtask

  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // stimulus
  initial begin
    rot_sb         = new();
    start          = 1'b0;
    first_value_i  = '0;
    second_value_i = '0;
    idle_pct       = 0;
    rst_ni         = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners: zeros, one side zero, extremes, equal magnitudes
    send_pair('0, '0);
    send_pair(32'd65536, '0);
    send_pair(-32'd65536, '0);
    send_pair('0, 32'd1);
    send_pair('0, -32'd1);
    send_pair(MAX_V, '0);
    send_pair(MIN_V, '0);
    send_pair('0, MIN_V);
    send_pair('0, MAX_V);
    send_pair(MIN_V, MIN_V);
    send_pair(MAX_V, MAX_V);
    send_pair(MAX_V, MIN_V);
    send_pair(MIN_V, MAX_V);
    send_pair(32'd1, 32'd1);
    send_pair(-32'd1, 32'd1);
    send_pair(32'd3, -32'd4);
    send_pair(-32'd1, -32'd1);
    send_pair(32'd1, MIN_V);
    send_pair(MAX_V, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_pair(32'h5555_5555, 32'hFFFF_FFFF);

    // back to back, sparse sender, mixed
    idle_pct = 0;
    send_random(600);
    idle_pct = 83;
    send_random(550);
    idle_pct = 27;
    send_random(550);
    start = 1'b0;

    while (rot_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (rot_sb.errors == 0) begin
      $display("givens_rotation_generator_core_tb OK");
    end else begin
      $display("givens_rotation_generator_core_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("givens_rotation_generator_core_tb NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/grg_pkg.sv
hw/rtl/grg_isqrt_pipe.sv
hw/rtl/givens_rotation_generator_core.sv
test/givens_rotation_generator_core_tb.sv
